@@ rtl/prlm_pkg.sv @@
`default_nettype none
package prlm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int GAIN_W      = 16;
    localparam int LEVEL_W     = SAMPLE_BITS;
    localparam int SHOWN_W     = LEVEL_W + FRAC_BITS;
    // squares and their mean: at most 2^(2*(SAMPLE_BITS-1))
    localparam int SQ_W        = 2 * SAMPLE_BITS - 1;
    localparam int MEAN_W      = SQ_W;
    localparam int ROOT_W      = MEAN_W + 1;
    localparam int SQRT_STEPS  = SAMPLE_BITS;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_ABSENT = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OP_SAMPLE,
        OP_SAMPLE_LAST,
        OP_TICK,
        OP_CLEAR,
        OP_ABSENT
    } op_t;

    typedef struct packed {
        op_t                    op;
        logic [LEVEL_W-1:0]     mag;
    } q_entry_t;

endpackage
`default_nettype wire

@@ rtl/prlm_front.sv @@
`default_nettype none
module prlm_front (
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [15:0]                    s_axis_tdata,   // sample
    input  wire logic                           s_axis_tlast,   // last
    input  wire logic [1:0]                     s_axis_tuser,   // command
    output logic                                push_valid,
    input  wire logic                           push_ready,
    output prlm_pkg::q_entry_t                  push_data
);
    import prlm_pkg::*;

    logic [SAMPLE_BITS-1:0] sample;

    assign sample        = s_axis_tdata[SAMPLE_BITS-1:0];
    assign s_axis_tready = push_ready;
    assign push_valid    = s_axis_tvalid;

    always_comb
    begin
        // two's complement magnitude; the most negative code maps to 2^(N-1) exactly
        push_data.mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
        case (cmd_t'(s_axis_tuser))
            CMD_SAMPLE: push_data.op = s_axis_tlast ? OP_SAMPLE_LAST : OP_SAMPLE;
            CMD_TICK:   push_data.op = OP_TICK;
            CMD_CLEAR:  push_data.op = OP_CLEAR;
            CMD_ABSENT: push_data.op = OP_ABSENT;
            default:    push_data.op = OP_ABSENT;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/prlm_queue.sv @@
`default_nettype none
module prlm_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push_valid,
    output logic                        push_ready,
    input  wire prlm_pkg::q_entry_t     push_data,
    output logic                        pop_valid,
    input  wire logic                   pop_ready,
    output prlm_pkg::q_entry_t          pop_data
);
    import prlm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    q_entry_t           mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/prlm_back.sv @@
`default_nettype none
module prlm_back #(
    parameter int MAX_BUFFER = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [prlm_pkg::GAIN_W-1:0]    gain,
    input  wire logic                           pop_valid,
    output logic                                pop_ready,
    input  wire prlm_pkg::q_entry_t             pop_data,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [31:0]                         m_axis_tdata    // peak_level, rms_level
);
    import prlm_pkg::*;

    localparam int CNT_W  = $clog2(MAX_BUFFER + 1);
    localparam int SUM_W  = SQ_W - 1 + CNT_W;
    localparam int DIT_W  = $clog2(SUM_W);
    localparam int SIT_W  = $clog2(SQRT_STEPS);
    localparam int PROD_W = SHOWN_W + GAIN_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_FIN,
        ST_REL
    } state_t;

    state_t                 state_reg,       state_next;
    logic [LEVEL_W-1:0]     peak_reg,        peak_next;
    logic [SUM_W-1:0]       sum_reg,         sum_next;
    logic [CNT_W-1:0]       cnt_reg,         cnt_next;
    logic [LEVEL_W-1:0]     peak_tgt_reg,    peak_tgt_next;
    logic [LEVEL_W-1:0]     rms_tgt_reg,     rms_tgt_next;
    logic [SHOWN_W-1:0]     peak_shown_reg,  peak_shown_next;
    logic [SHOWN_W-1:0]     rms_shown_reg,   rms_shown_next;
    logic [CNT_W-1:0]       rem_reg,         rem_next;
    logic [DIT_W-1:0]       div_it_reg,      div_it_next;
    logic [MEAN_W-1:0]      sq_v_reg,        sq_v_next;
    logic [ROOT_W-1:0]      root_reg,        root_next;
    logic [MEAN_W-1:0]      sq_bit_reg,      sq_bit_next;
    logic [SIT_W-1:0]       sq_it_reg,       sq_it_next;
    logic                   rel_sel_reg,     rel_sel_next;
    logic                   m_valid_reg,     m_valid_next;
    logic [31:0]            m_data_reg,      m_data_next;

    logic                   out_free;
    logic [2*SAMPLE_BITS-1:0] sq_full;
    logic [SQ_W-1:0]        sq;
    logic [CNT_W:0]         trial;
    logic                   trial_ge;
    logic [ROOT_W-1:0]      sq_try;
    logic                   sq_ge;
    logic [LEVEL_W-1:0]     rel_tgt;
    logic [SHOWN_W-1:0]     rel_shown;
    logic [SHOWN_W-1:0]     rel_t;
    logic                   rel_up;
    logic [SHOWN_W-1:0]     rel_diff;
    logic [PROD_W-1:0]      rel_prod;
    logic [SHOWN_W-1:0]     rel_step;
    logic [SHOWN_W-1:0]     rel_new;
    logic [SHOWN_W-1:0]     peak_t;
    logic [SHOWN_W-1:0]     rms_t;
    logic [LEVEL_W-1:0]     rms_val;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign pop_ready     = (state_reg == ST_IDLE) && (pop_data.op != OP_TICK || out_free);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign sq_full = pop_data.mag * pop_data.mag;
    assign sq      = sq_full[SQ_W-1:0];

    // restoring divide, one quotient bit a cycle shifted into the sum register
    assign trial    = {rem_reg, sum_reg[SUM_W-1]};
    assign trial_ge = (trial >= {1'b0, cnt_reg});

    assign sq_try = root_reg + {1'b0, sq_bit_reg};
    assign sq_ge  = ({1'b0, sq_v_reg} >= sq_try);

    // one shared release unit, peak first then RMS
    assign rel_tgt   = rel_sel_reg ? rms_tgt_reg : peak_tgt_reg;
    assign rel_shown = rel_sel_reg ? rms_shown_reg : peak_shown_reg;
    assign rel_t     = {rel_tgt, FRAC_BITS'(0)};
    assign rel_up    = (rel_t >= rel_shown);
    assign rel_diff  = rel_up ? (rel_t - rel_shown) : (rel_shown - rel_t);
    assign rel_prod  = rel_diff * gain;
    assign rel_step  = rel_prod[PROD_W-1:GAIN_W];
    assign rel_new   = rel_up ? (rel_shown + rel_step) : (rel_shown - rel_step);

    assign peak_t  = {peak_reg, FRAC_BITS'(0)};
    assign rms_val = (cnt_reg == '0) ? '0 : root_reg[LEVEL_W-1:0];
    assign rms_t   = {rms_val, FRAC_BITS'(0)};

    always_comb
    begin
        state_next      = state_reg;
        peak_next       = peak_reg;
        sum_next        = sum_reg;
        cnt_next        = cnt_reg;
        peak_tgt_next   = peak_tgt_reg;
        rms_tgt_next    = rms_tgt_reg;
        peak_shown_next = peak_shown_reg;
        rms_shown_next  = rms_shown_reg;
        rem_next        = rem_reg;
        div_it_next     = div_it_reg;
        sq_v_next       = sq_v_reg;
        root_next       = root_reg;
        sq_bit_next     = sq_bit_reg;
        sq_it_next      = sq_it_reg;
        rel_sel_next    = rel_sel_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_data_next     = m_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid && pop_ready)
                begin
                    case (pop_data.op)
                        OP_SAMPLE, OP_SAMPLE_LAST:
                        begin
                            // drop samples beyond the buffer limit
                            if (cnt_reg < CNT_W'(MAX_BUFFER))
                            begin
                                if (pop_data.mag > peak_reg)
                                begin
                                    peak_next = pop_data.mag;
                                end
                                sum_next = sum_reg + SUM_W'(sq);
                                cnt_next = cnt_reg + 1'b1;
                            end
                            if (pop_data.op == OP_SAMPLE_LAST)
                            begin
                                rem_next    = '0;
                                div_it_next = DIT_W'(SUM_W - 1);
                                state_next  = ST_DIV;
                            end
                        end
                        OP_TICK:
                        begin
                            m_valid_next = 1'b1;
                            m_data_next  = {rms_shown_reg[SHOWN_W-1:FRAC_BITS],
                                            peak_shown_reg[SHOWN_W-1:FRAC_BITS]};
                            rel_sel_next = 1'b0;
                            state_next   = ST_REL;
                        end
                        OP_CLEAR:
                        begin
                            peak_next       = '0;
                            sum_next        = '0;
                            cnt_next        = '0;
                            peak_tgt_next   = '0;
                            rms_tgt_next    = '0;
                            peak_shown_next = '0;
                            rms_shown_next  = '0;
                        end
                        OP_ABSENT:
                        begin
                            peak_next     = '0;
                            sum_next      = '0;
                            cnt_next      = '0;
                            peak_tgt_next = '0;
                            rms_tgt_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                rem_next = trial_ge ? CNT_W'(trial - {1'b0, cnt_reg}) : trial[CNT_W-1:0];
                sum_next = {sum_reg[SUM_W-2:0], trial_ge};
                div_it_next = div_it_reg - 1'b1;
                if (div_it_reg == '0)
                begin
                    sq_v_next   = sum_next[MEAN_W-1:0];
                    root_next   = '0;
                    sq_bit_next = MEAN_W'(1) << (MEAN_W - 1);
                    sq_it_next  = SIT_W'(SQRT_STEPS - 1);
                    state_next  = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sq_ge)
                begin
                    sq_v_next = sq_v_reg - sq_try[MEAN_W-1:0];
                    root_next = (root_reg >> 1) + {1'b0, sq_bit_reg};
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                sq_it_next  = sq_it_reg - 1'b1;
                if (sq_it_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                peak_tgt_next   = peak_reg;
                rms_tgt_next    = rms_val;
                peak_shown_next = (peak_t > peak_shown_reg) ? peak_t : peak_shown_reg;
                rms_shown_next  = (rms_t > rms_shown_reg) ? rms_t : rms_shown_reg;
                peak_next       = '0;
                sum_next        = '0;
                cnt_next        = '0;
                state_next      = ST_IDLE;
            end
            ST_REL:
            begin
                if (rel_sel_reg)
                begin
                    rms_shown_next = rel_new;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    peak_shown_next = rel_new;
                end
                rel_sel_next = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            peak_reg       <= '0;
            sum_reg        <= '0;
            cnt_reg        <= '0;
            peak_tgt_reg   <= '0;
            rms_tgt_reg    <= '0;
            peak_shown_reg <= '0;
            rms_shown_reg  <= '0;
            div_it_reg     <= '0;
            sq_it_reg      <= '0;
            rel_sel_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            peak_reg       <= peak_next;
            sum_reg        <= sum_next;
            cnt_reg        <= cnt_next;
            peak_tgt_reg   <= peak_tgt_next;
            rms_tgt_reg    <= rms_tgt_next;
            peak_shown_reg <= peak_shown_next;
            rms_shown_reg  <= rms_shown_next;
            div_it_reg     <= div_it_next;
            sq_it_reg      <= sq_it_next;
            rel_sel_reg    <= rel_sel_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        sq_v_reg   <= sq_v_next;
        root_reg   <= root_next;
        sq_bit_reg <= sq_bit_next;
        m_data_reg <= m_data_next;
    end

endmodule
`default_nettype wire

@@ rtl/peak_rms_level_meter.sv @@
// Sample word: handled in ST_IDLE of the back end; a word marked last adds a restoring
// divide in ST_DIV, a square root in ST_SQRT and an update of the levels in ST_FIN.
// Tick word: result registered on acceptance, then ST_REL releases peak and then RMS.
// The back end takes no new word outside ST_IDLE; a four-word queue decouples the input.
// Reset (asynchronous, active low) zeroes all levels and accumulators, gain 6554.
`default_nettype none
module peak_rms_level_meter #(
    parameter int MAX_BUFFER = 4096
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [15:0]    s_axis_tdata,   // sample
    input  wire logic           s_axis_tlast,   // last
    input  wire logic [1:0]     s_axis_tuser,   // command
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [31:0]         m_axis_tdata,   // peak_level, rms_level
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [15:0]    cfg_data        // release_gain
);
    import prlm_pkg::*;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(6554);

    logic [GAIN_W-1:0]  gain_reg;
    logic               push_valid;
    logic               push_ready;
    q_entry_t           push_data;
    logic               pop_valid;
    logic               pop_ready;
    q_entry_t           pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            gain_reg <= cfg_data[GAIN_W-1:0];
        end
    end

    prlm_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    prlm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    prlm_back #(
        .MAX_BUFFER (MAX_BUFFER)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .gain          (gain_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

import prlm_pkg::*;

localparam int          BUF_MAX      = 4096;
localparam logic [15:0] GAIN_RESET   = 16'd6554;
localparam int          DRAIN_CYCLES = 400;
localparam int          HOLD_CYCLES  = 300;
localparam int          IDLE_LIMIT   = 4000;

// Tracks the meter state and the level reports still owed by the block.
class meter_model;
    logic [15:0] gain;
    logic [16:0] buf_peak;
    logic [42:0] buf_sumsq;
    logic [12:0] buf_count;
    logic [15:0] peak_goal;
    logic [15:0] rms_goal;
    logic [23:0] peak_disp;
    logic [23:0] rms_disp;
    logic [31:0] owed_reports[$];
    int          errors;
    int          reports;

    function new();
        gain    = GAIN_RESET;
        errors  = 0;
        reports = 0;
        clear_all();
    endfunction

    function void clear_buffer();
        buf_peak  = '0;
        buf_sumsq = '0;
        buf_count = '0;
    endfunction

    function void clear_all();
        clear_buffer();
        peak_goal = '0;
        rms_goal  = '0;
        peak_disp = '0;
        rms_disp  = '0;
    endfunction

    function logic [15:0] int_sqrt(logic [63:0] v);
        logic [31:0] r;
        logic [31:0] c;
        logic [63:0] c2;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            c  = r | (32'd1 << b);
            c2 = 64'(c) * 64'(c);
            if (c2 <= v)
                r = c;
        end
        return r[15:0];
    endfunction

    function logic [23:0] rise(logic [15:0] goal, logic [23:0] disp);
        logic [23:0] t;
        t = {goal, 8'd0};
        return (t > disp) ? t : disp;
    endfunction

    // Truncate the step magnitude so the level never overshoots its goal.
    function logic [23:0] release_move(logic [15:0] goal, logic [23:0] disp);
        logic [63:0] t;
        logic [63:0] d;
        t = 64'({goal, 8'd0});
        if (t >= 64'(disp))
        begin
            d = (t - 64'(disp)) * 64'(gain);
            return disp + 24'(d >> 16);
        end
        d = (64'(disp) - t) * 64'(gain);
        return disp - 24'(d >> 16);
    endfunction

    function void note_word(cmd_t cmd, logic [15:0] smp, logic lst);
        logic [16:0] mag;
        logic [63:0] mean;
        case (cmd)
            CMD_SAMPLE:
            begin
                // drop samples once the buffer is full, but honour last
                if (buf_count < BUF_MAX)
                begin
                    mag = smp[15] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
                    if (mag > buf_peak)
                        buf_peak = mag;
                    buf_sumsq = buf_sumsq + 43'(mag) * 43'(mag);
                    buf_count = buf_count + 13'd1;
                end
                if (lst)
                begin
                    mean = (buf_count != 0) ? 64'(buf_sumsq) / 64'(buf_count) : 64'd0;
                    peak_goal = buf_peak[15:0];
                    rms_goal  = int_sqrt(mean);
                    peak_disp = rise(peak_goal, peak_disp);
                    rms_disp  = rise(rms_goal, rms_disp);
                    clear_buffer();
                end
            end
            CMD_TICK:
            begin
                owed_reports.push_back({rms_disp[23:8], peak_disp[23:8]});
                peak_disp = release_move(peak_goal, peak_disp);
                rms_disp  = release_move(rms_goal, rms_disp);
            end
            CMD_CLEAR:
                clear_all();
            default:
            begin
                peak_goal = '0;
                rms_goal  = '0;
                clear_buffer();
            end
        endcase
    endfunction

    function void check_report(logic [31:0] word);
        logic [31:0] want;
        reports++;
        if (owed_reports.size() == 0)
        begin
            $display("%0t: unexpected report, expected none, got peak %0d rms %0d",
                     $time, word[15:0], word[31:16]);
            errors++;
            return;
        end
        want = owed_reports.pop_front();
        if (word[15:0] !== want[15:0])
        begin
            $display("%0t: peak_level expected %0d, got %0d", $time, want[15:0], word[15:0]);
            errors++;
        end
        if (word[31:16] !== want[31:16])
        begin
            $display("%0t: rms_level expected %0d, got %0d", $time, want[31:16], word[31:16]);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // sample
    logic        s_axis_tlast  = 1'b0;  // last
    logic [1:0]  s_axis_tuser  = '0;    // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // peak_level, rms_level
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data      = '0;    // release_gain

    meter_model meter = new();

    int words_sent     = 0;
    int gain_settings  = 1;
    int stall_requests = 0;
    int stall_served   = 0;
    int idle_cycles    = 0;
    bit no_idle        = 1'b0;

    peak_rms_level_meter #(
        .MAX_BUFFER (BUF_MAX)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_sample(int shift);
        int          r;
        logic [15:0] v;
        r = $urandom_range(0, 19);
        case (r)
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default:
            begin
                v = 16'($urandom) >> shift;
                if ($urandom_range(0, 1) == 1)
                    v = -v;
                return v;
            end
        endcase
    endfunction

    task automatic send_word(cmd_t cmd, logic [15:0] smp, logic lst);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        meter.note_word(cmd, smp, lst);
        words_sent++;
    endtask

    // sample and last carry junk on these commands
    task automatic send_control(cmd_t cmd);
        send_word(cmd, 16'($urandom), 1'($urandom));
    endtask

    task automatic send_buffer(int len, int shift);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_control(CMD_TICK);
            send_word(CMD_SAMPLE, pick_sample(shift), i == len - 1);
        end
    endtask

    task automatic run_random(int n);
        int start;
        int r;
        int len;
        start = words_sent;
        while (words_sent - start < n)
        begin
            r   = $urandom_range(0, 99);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 150) : $urandom_range(1, 16);
            if (r < 56)
                send_buffer(len, $urandom_range(0, 15));
            else if (r < 62)
            begin
                // abandon a half-built buffer
                repeat ($urandom_range(1, 6))
                    send_word(CMD_SAMPLE, pick_sample(0), 1'b0);
                send_control(($urandom_range(0, 1) == 1) ? CMD_ABSENT : CMD_CLEAR);
            end
            else if (r < 90)
                repeat ($urandom_range(1, 3))
                    send_control(CMD_TICK);
            else if (r < 94)
                send_control(CMD_CLEAR);
            else
                send_control(CMD_ABSENT);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (meter.owed_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_gain(logic [15:0] g);
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        meter.gain = g;
        gain_settings++;
    endtask

    task automatic run_directed();
        send_control(CMD_TICK);
        send_word(CMD_SAMPLE, 16'h7FFF, 1'b1);
        send_control(CMD_TICK);
        send_word(CMD_SAMPLE, 16'h8000, 1'b1);
        send_control(CMD_TICK);
        send_control(CMD_TICK);
        send_word(CMD_SAMPLE, 16'h0000, 1'b0);
        send_word(CMD_SAMPLE, 16'hFFFF, 1'b0);
        send_word(CMD_SAMPLE, 16'h0001, 1'b1);
        send_control(CMD_TICK);
        send_control(CMD_CLEAR);
        send_control(CMD_TICK);
        send_word(CMD_SAMPLE, 16'd1000, 1'b0);
        send_control(CMD_ABSENT);
        send_control(CMD_TICK);
        send_word(CMD_SAMPLE, 16'h8000, 1'b0);
        send_word(CMD_SAMPLE, 16'h7FFF, 1'b1);
        send_control(CMD_ABSENT);
        send_control(CMD_TICK);
        send_control(CMD_TICK);
        send_word(CMD_SAMPLE, 16'h0000, 1'b1);
        send_control(CMD_TICK);
    endtask

    // Result side: random holds, plus a long hold-off whenever one is requested.
    initial
    begin
        int hold;
        forever
        begin
            if (stall_served != stall_requests)
            begin
                stall_served = stall_requests;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                hold = gap_len();
                m_axis_tready <= (hold == 0);
                repeat ((hold == 0) ? 1 : hold) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            meter.check_report(m_axis_tdata);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("[peak_rms_level_meter] ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gain
        run_directed();
        run_random(200);
        drain();

        // gain of zero: levels never fall on release
        write_gain(16'h0000);
        no_idle = 1'b1;
        run_random(150);
        no_idle = 1'b0;
        drain();

        // near-unity gain, and fill the block while the result side holds off
        write_gain(16'hFFFF);
        run_random(100);
        stall_requests++;
        no_idle = 1'b1;
        repeat (40)
            send_control(CMD_TICK);
        no_idle = 1'b0;
        run_random(50);
        drain();

        write_gain(16'h0001);
        run_random(100);
        drain();

        write_gain(16'($urandom_range(2, 65534)));
        send_control(CMD_TICK);
        send_control(CMD_TICK);
        run_random(150);
        drain();

        $display("Checked %0d level reports from %0d input words across %0d gain settings,",
                 meter.reports, words_sent, gain_settings);
        $display("with clears, absent channel, abandoned buffers and a long output hold-off.");
        if (meter.errors == 0 && meter.owed_reports.size() == 0)
            $display("[peak_rms_level_meter] OK");
        else
            $display("[peak_rms_level_meter] ERROR");
        $finish;
    end
endmodule

@@ files.f @@
rtl/prlm_pkg.sv
rtl/prlm_front.sv
rtl/prlm_queue.sv
rtl/prlm_back.sv
rtl/peak_rms_level_meter.sv
sim/tb_top.sv
